// ===== rtl/mwda_pkg.sv =====
// Shared constants and types for the median window decimating average block.
package mwda_pkg;

  // Item field widths
  localparam int CH_W  = 2;
  localparam int SMP_W = 12;

  // Window and channel sizing
  localparam int WINDOW   = 16;
  localparam int CHANNELS = 4;
  localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int ADDR_W   = CH_W + SLOT_W;
  localparam int MED_IX   = WINDOW / 2;

  // Decimating average: eight medians, shift by three
  localparam int AVG_LEN   = 8;
  localparam int AVG_SHIFT = 3;
  localparam int CNT_W     = AVG_SHIFT;
  localparam int SUM_W     = SMP_W + AVG_SHIFT;

  // Link between neighbouring sort cells: the cell's entry once the old
  // sample is removed, whether it lies past the end, and whether it sorts
  // below the new sample.
  typedef struct packed {
    logic [SMP_W-1:0] t;
    logic             inf;
    logic             lt;
  } link_t;

endpackage

// ===== rtl/mwda_in_if.sv =====
// Input channel: valid/ready handshake carrying channel and sample.
interface mwda_in_if;
  import mwda_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [SMP_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

// ===== rtl/mwda_out_if.sv =====
// Output channel: valid/ready handshake carrying the filtered value.
interface mwda_out_if;
  import mwda_pkg::*;

  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] filtered;
  logic             is_average;

  modport source (output valid, output filtered, output is_average, input ready);
  modport sink   (input valid, input filtered, input is_average, output ready);
endinterface

// ===== rtl/mwda_ring.sv =====
// Per-channel ring store of raw samples; returns the entry being overwritten.
module mwda_ring import mwda_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [CH_W-1:0]  ch_i,
  input  logic [SMP_W-1:0] sample_i,
  output logic [SMP_W-1:0] old_o
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [SMP_W-1:0]  mem_q [DEPTH];
  logic [SMP_W-1:0]  rd_q;
  logic              rd_vld_q;
  logic [SLOT_W-1:0] slot_q [CHANNELS];
  logic              wrap_q [CHANNELS];
  logic [SLOT_W-1:0] slot_d;
  logic [ADDR_W-1:0] addr;

  // Slot advances before the write and wraps at the window end
  always_comb begin
    if (slot_q[ch_i] == SLOT_W'(WINDOW - 1)) begin
      slot_d = '0;
    end else begin
      slot_d = slot_q[ch_i] + SLOT_W'(1);
    end
  end

  assign addr = {ch_i, slot_d};

  // Slot pointers; the wrap flag marks a channel whose every entry is written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        slot_q[i] <= '0;
        wrap_q[i] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
    end else if (wr_i) begin
      slot_q[ch_i] <= slot_d;
      rd_vld_q     <= wrap_q[ch_i];
      if (slot_d == '0) begin
        wrap_q[ch_i] <= 1'b1;
      end
    end
  end

  // Sample memory, read before write at the same address
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      rd_q        <= mem_q[addr];
      mem_q[addr] <= sample_i;
    end
  end

  // Entries never written read as the cleared value
  assign old_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/mwda_sort_cell.sv =====
// One cell of the sorted window: drops the old sample and inserts the new one.
module mwda_sort_cell import mwda_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_i,
  input  logic [CH_W-1:0]  ch_i,
  input  logic [SMP_W-1:0] old_i,
  input  logic [SMP_W-1:0] new_i,
  input  link_t            left_i,
  input  logic [SMP_W-1:0] right_s_i,
  input  logic             right_inf_i,
  output logic [SMP_W-1:0] s_o,
  output link_t            link_o,
  output logic [SMP_W-1:0] r_o
);

  logic [SMP_W-1:0] vals_q [CHANNELS];
  logic             below_old;

  assign s_o       = vals_q[ch_i];
  assign below_old = s_o < old_i;

  // After removal, entries at or past the old sample shift down one place
  always_comb begin
    link_o.t   = below_old ? s_o : right_s_i;
    link_o.inf = !below_old && right_inf_i;
    link_o.lt  = !link_o.inf && (link_o.t < new_i);
  end

  // Insertion: keep, take the new sample, or take the left neighbour's entry
  always_comb begin
    if (link_o.lt) begin
      r_o = link_o.t;
    end else if (left_i.lt) begin
      r_o = new_i;
    end else begin
      r_o = left_i.t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        vals_q[i] <= '0;
      end
    end else if (upd_i) begin
      vals_q[ch_i] <= r_o;
    end
  end

endmodule

// ===== rtl/median_window_decimating_average.sv =====
// Top level of the multi-channel median filter with decimating average.
//
// Input channel in_i carries a channel number and a 12-bit sample; output
// channel out_o returns one item per input item: the median of that
// channel's last sixteen samples, or on every eighth median of a channel
// the mean of those eight medians with is_average set.
// An item is first taken into the item registers while the ring memory is read at the
// slot being overwritten (its one port is read and written together); then
// the row of sort cells drops the old sample, inserts the new
// one and the median is tapped from the middle cell into the output
// register, which drives out_o.valid. A new item is accepted only once
// the previous one has left the cell stage.
// A finished item waits in the output register while the next item is
// taken; if the receiver still stalls when that next item is done, the
// block holds it in the cell stage and in_i.ready stays low.
// Reset clears the windows to zero, the slot pointers, the median sums
// and counts, and empties both stages; no clearing pass is needed.
// Items naming a channel outside the configured count return zero.
module median_window_decimating_average import mwda_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mwda_in_if.sink      in_i,
  mwda_out_if.source   out_o
);

  logic             accept;
  logic             ch_ok;
  logic             fire;
  logic             busy_q;
  logic [CH_W-1:0]  ch_q;
  logic [SMP_W-1:0] smp_q;
  logic             chv_q;
  logic [SMP_W-1:0] old_w;

  logic [SMP_W-1:0] s_w    [WINDOW];
  link_t            link_w [WINDOW];
  logic [SMP_W-1:0] r_w    [WINDOW];
  logic [SMP_W-1:0] med;

  logic [SUM_W-1:0] sum_q [CHANNELS];
  logic [CNT_W-1:0] cnt_q [CHANNELS];
  logic [SUM_W-1:0] sum_d;
  logic             last_med;

  logic             out_vld_q;
  logic [SMP_W-1:0] filt_q;
  logic             avg_q;

  // Handshake: one item in the cell stage at a time
  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && in_i.ready;
  assign ch_ok      = int'(in_i.channel) < CHANNELS;
  assign fire       = busy_q && (!out_vld_q || out_o.ready);

  // Ring store of raw samples
  mwda_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept && ch_ok),
    .ch_i     (in_i.channel),
    .sample_i (in_i.sample),
    .old_o    (old_w)
  );

  // First stage item registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chv_q  <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
      chv_q  <= ch_ok;
    end else if (fire) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q  <= in_i.channel;
      smp_q <= in_i.sample;
    end
  end

  // Row of sort cells, each holding one rank of every channel's window
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    link_t            left;
    logic [SMP_W-1:0] right_s;
    logic             right_inf;

    if (i == 0) begin : g_first
      assign left = '{t: '0, inf: 1'b0, lt: 1'b1};
    end else begin : g_mid
      assign left = link_w[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign right_s   = '0;
      assign right_inf = 1'b1;
    end else begin : g_inner
      assign right_s   = s_w[i+1];
      assign right_inf = 1'b0;
    end

    mwda_sort_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .upd_i       (fire && chv_q),
      .ch_i        (ch_q),
      .old_i       (old_w),
      .new_i       (smp_q),
      .left_i      (left),
      .right_s_i   (right_s),
      .right_inf_i (right_inf),
      .s_o         (s_w[i]),
      .link_o      (link_w[i]),
      .r_o         (r_w[i])
    );
  end

  assign med      = r_w[MED_IX];
  assign sum_d    = sum_q[ch_q] + SUM_W'(med);
  assign last_med = cnt_q[ch_q] == CNT_W'(AVG_LEN - 1);

  // Per-channel median sum and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (fire && chv_q) begin
      if (last_med) begin
        sum_q[ch_q] <= '0;
        cnt_q[ch_q] <= '0;
      end else begin
        sum_q[ch_q] <= sum_d;
        cnt_q[ch_q] <= cnt_q[ch_q] + CNT_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (!chv_q) begin
        filt_q <= '0;
        avg_q  <= 1'b0;
      end else if (last_med) begin
        filt_q <= SMP_W'(sum_d >> AVG_SHIFT);
        avg_q  <= 1'b1;
      end else begin
        filt_q <= med;
        avg_q  <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.filtered   = filt_q;
  assign out_o.is_average = avg_q;

endmodule

// ===== tb/mwda_checker.sv =====
// Checker for the median window decimating average block: predicts and compares results.
module mwda_checker import mwda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mwda_in_if          in_mon,
  mwda_out_if         out_mon,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned medians_o,
  output int unsigned means_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PRINTS = 20;

  typedef struct packed {
    logic [SMP_W-1:0] filtered;
    logic             is_average;
  } filt_res_t;

  // Predicted copy of the per-channel state
  logic [SMP_W-1:0]  window_q [CHANNELS][WINDOW];
  logic [SLOT_W-1:0] slot_q   [CHANNELS];
  logic [SUM_W-1:0]  sum_q    [CHANNELS];
  int unsigned       count_q  [CHANNELS];

  filt_res_t   expected_q [$];
  int unsigned errors_n;
  int unsigned pending_n;
  int unsigned medians_n;
  int unsigned means_n;

  assign errors_o  = errors_n;
  assign pending_o = pending_n;
  assign medians_o = medians_n;
  assign means_o   = means_n;

  // Middle element of a channel's window once sorted ascending
  function automatic logic [SMP_W-1:0] window_median(input int ch);
    logic [SMP_W-1:0] srt [WINDOW];
    logic [SMP_W-1:0] v;
    int a;
    int b;
    for (a = 0; a < WINDOW; a++) srt[a] = window_q[ch][a];
    for (a = 1; a < WINDOW; a++) begin
      v = srt[a];
      b = a;
      while (b > 0 && srt[b-1] > v) begin
        srt[b] = srt[b-1];
        b--;
      end
      srt[b] = v;
    end
    return srt[MED_IX];
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (errors_n < MAX_PRINTS)
      $display("%0t mismatch: %s got %0d, expected %0d", $realtime, what, got, want);
    errors_n++;
  endtask

  // Advance the predicted state for one sample and queue the expected item
  task automatic take_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
    filt_res_t        res;
    logic [SMP_W-1:0] med;
    int               nxt;
    res = '0;
    if (int'(ch) < CHANNELS) begin
      nxt = int'(slot_q[ch]) + 1;
      if (nxt >= WINDOW) nxt = 0;
      slot_q[ch]           = SLOT_W'(nxt);
      window_q[ch][nxt]    = smp;
      med                  = window_median(int'(ch));
      res.filtered         = med;
      sum_q[ch]            = SUM_W'(sum_q[ch] + med);
      count_q[ch]++;
      if (count_q[ch] >= AVG_LEN) begin
        res.filtered   = SMP_W'(sum_q[ch] >> AVG_SHIFT);
        res.is_average = 1'b1;
        sum_q[ch]      = '0;
        count_q[ch]    = 0;
      end
    end
    expected_q.push_back(res);
    pending_n++;
  endtask

  // Watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int s = 0; s < WINDOW; s++) window_q[c][s] = '0;
        slot_q[c]  = '0;
        sum_q[c]   = '0;
        count_q[c] = 0;
      end
      expected_q.delete();
      errors_n  = 0;
      pending_n = 0;
      medians_n = 0;
      means_n   = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) take_sample(in_mon.channel, in_mon.sample);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item, filtered", out_mon.filtered, 0);
        end else begin
          filt_res_t want;
          want = expected_q.pop_front();
          pending_n--;
          if (out_mon.filtered !== want.filtered)
            report_mismatch("filtered", out_mon.filtered, want.filtered);
          if (out_mon.is_average !== want.is_average)
            report_mismatch("is_average", out_mon.is_average, want.is_average);
          if (want.is_average) means_n++;
          else medians_n++;
        end
      end
    end
  end

endmodule

// ===== tb/tb_median_window_decimating_average.sv =====
// Testbench top for the median window decimating average block: stimulus and verdict.
module tb_median_window_decimating_average;
  timeunit 1ns;
  timeprecision 1ps;
  import mwda_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned IDLE_LIMIT   = 4000;

  logic clk_i;
  logic rst_ni;

  mwda_in_if  in_if ();
  mwda_out_if out_if ();

  int unsigned errors_n;
  int unsigned pending_n;
  int unsigned medians_n;
  int unsigned means_n;
  int unsigned sent_n;
  int unsigned idle_n;
  bit          steady;
  int          level_q [CHANNELS];

  median_window_decimating_average i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mwda_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .errors_o  (errors_n),
    .pending_o (pending_n),
    .medians_o (medians_n),
    .means_o   (means_n)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then long; none in steady stretches
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sample value: extremes, uniform, or around a drifting per-channel level
  function automatic logic [SMP_W-1:0] pick_sample(input logic [CH_W-1:0] ch);
    int unsigned r;
    int          lv;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 50) return SMP_W'($urandom);
    lv = level_q[ch] + int'($urandom_range(0, 128)) - 64;
    if (lv < 0) lv = 0;
    if (lv > 4095) lv = 4095;
    return SMP_W'(lv);
  endfunction

  // Offer one item at the falling edge and hold it until taken
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.channel <= ch;
    in_if.sample  <= smp;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    sent_n++;
  endtask

  // Receiver: runs of ready broken by stalls
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      stall = idle_len();
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  // Watchdog: cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_n <= 0;
    end else if (idle_n >= IDLE_LIMIT) begin
      $display("median_window_decimating_average verification failed");
      $finish;
    end else begin
      idle_n <= idle_n + 1;
    end
  end

  // Stimulus and verdict
  initial begin
    logic [CH_W-1:0] ch;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.channel = '0;
    in_if.sample  = '0;
    steady        = 1'b0;
    sent_n        = 0;
    for (int c = 0; c < CHANNELS; c++) level_q[c] = $urandom_range(0, 4095);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: full-scale run past the slot wrap, giving both a small and a
    // full-scale mean, then alternating bit patterns, single bits and extremes on the other channels
    repeat (17) send_sample(CH_W'(1), '1);
    send_sample(CH_W'(0), 12'hAAA);
    send_sample(CH_W'(0), 12'h555);
    send_sample(CH_W'(2), 12'h001);
    send_sample(CH_W'(2), 12'h800);
    send_sample(CH_W'(3), '1);
    send_sample(CH_W'(3), '0);
    send_sample(CH_W'(3), 12'h7FF);
    send_sample(CH_W'(0), '0);

    // Random: bursts on one channel mixed with hopping, steady stretches between
    ch = '0;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      steady = ((i / 200) % 3) == 1;
      if ($urandom_range(0, 99) >= 40) ch = CH_W'($urandom);
      if ($urandom_range(0, 99) < 3) level_q[ch] = $urandom_range(0, 4095);
      send_sample(ch, pick_sample(ch));
    end
    in_if.valid <= 1'b0;
    steady = 1'b0;

    // Drain, then keep watching for stray items
    while (pending_n != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d samples over %0d channels: %0d medians and %0d means checked",
             sent_n, CHANNELS, medians_n, means_n);
    $display("Mismatches: %0d, items still awaited: %0d", errors_n, pending_n);
    if (errors_n == 0 && pending_n == 0) begin
      $display("median_window_decimating_average verification clean");
    end else begin
      $display("median_window_decimating_average verification failed");
    end
    $finish;
  end

endmodule
